// File: hw/rtl/sbdr_pkg.sv
`timescale 1ns / 1ps
// sbdr_pkg: shared constants, reply command type and id byte selection
// for the serial download receiver. No dependencies.
package sbdr_pkg;

	localparam int ID_BYTES = 15;
	localparam int IDX_W    = (ID_BYTES > 1) ? $clog2(ID_BYTES) : 1;
	localparam int CNT_W    = $clog2(2 * ID_BYTES + 1);
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);

	localparam logic [7:0] CH_P = 8'h70;
	localparam logic [7:0] CH_W = 8'h77;
	localparam logic [7:0] CH_A = 8'h61;
	localparam logic [7:0] CH_D = 8'h64;
	localparam logic [7:0] CH_S = 8'h73;
	localparam logic [7:0] CH_C = 8'h63;
	localparam logic [7:0] CH_E = 8'h65;
	localparam logic [7:0] CH_K = 8'h6b;
	localparam logic [7:0] CH_R = 8'h72;

	localparam logic [3:0] ST_WAITING   = 4'd0;
	localparam logic [3:0] ST_CONNECTED = 4'd1;
	localparam logic [3:0] ST_WRONG_DEV = 4'd2;
	localparam logic [3:0] ST_ABORTED   = 4'd3;
	localparam logic [3:0] ST_DOWNLOAD  = 4'd4;
	localparam logic [3:0] ST_PROTO_ERR = 4'd5;
	localparam logic [3:0] ST_SYNC_ERR  = 4'd6;
	localparam logic [3:0] ST_CSUM_FAIL = 4'd7;
	localparam logic [3:0] ST_SUCCESS   = 4'd8;
	localparam logic [3:0] ST_RESETTING = 4'd9;

	localparam logic [0:0] CFG_ID_HIGH = 1'b0;
	localparam logic [0:0] CFG_ID_LOW  = 1'b1;

	typedef logic [ID_BYTES-1:0][7:0] version_t;

	typedef enum logic [1:0] {
		CMD_REPLY,
		CMD_COMMIT,
		CMD_BURST
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic [3:0] status;
		logic       rreq;
	} cmd_t;

	// id byte i: bytes 0..6 from the high register, 7..14 from the low one
	function automatic logic [7:0] id_byte(input logic [55:0] hi, input logic [63:0] lo,
		input logic [CNT_W-1:0] i);
		logic [7:0] r;
		int k;
		k = int'(i);
		if (k < 7) begin
			r = hi[8 * (6 - k) +: 8];
		end else if (k < 15) begin
			r = lo[8 * (14 - k) +: 8];
		end else begin
			r = 8'd0;
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/sbdr_front.sv
`timescale 1ns / 1ps
// sbdr_front: protocol state machine; takes received bytes, keeps the record
// checksum and version, and issues reply commands. Uses sbdr_pkg.
module sbdr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                acc,
	input  logic [7:0]          rx_byte,
	output logic                push,
	output sbdr_pkg::cmd_t      cmd,
	output sbdr_pkg::version_t rec_version
);
	import sbdr_pkg::*;

	typedef enum logic [3:0] {
		PH_WAIT, PH_CONN, PH_ABORTED, PH_SYNC, PH_VERSION, PH_LENGTH, PH_ADDR_HI,
		PH_ADDR_LO, PH_TYPE, PH_DATA, PH_CHECK, PH_DONE, PH_HALT
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] count_q, count_d, count_inc;
	logic [7:0] sum_q, sum_d, sum_add;
	logic [7:0] len_q, len_d;
	logic       ver_we;
	version_t   ver_q;

	assign count_inc   = count_q + 8'd1;
	assign sum_add     = sum_q + rx_byte;
	assign rec_version = ver_q;

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		sum_d   = sum_q;
		len_d   = len_q;
		ver_we  = 1'b0;
		push    = 1'b0;
		cmd     = '{kind: CMD_REPLY, tx_valid: 1'b0, tx_byte: 8'd0, status: ST_WAITING,
			rreq: 1'b0};
		if (acc) begin
			unique case (phase_q)
				PH_WAIT: begin
					if (rx_byte == CH_P) begin
						push     = 1'b1;
						cmd.kind = CMD_BURST;
						phase_d  = PH_CONN;
					end
				end
				PH_CONN: begin
					push = 1'b1;
					if (rx_byte == CH_W) begin
						cmd.status = ST_WRONG_DEV;
						phase_d    = PH_HALT;
					end else if (rx_byte == CH_A) begin
						cmd.status = ST_ABORTED;
						phase_d    = PH_ABORTED;
					end else if (rx_byte == CH_D) begin
						cmd.status = ST_DOWNLOAD;
						phase_d    = PH_SYNC;
					end else begin
						cmd.status = ST_PROTO_ERR;
						phase_d    = PH_HALT;
					end
				end
				PH_ABORTED, PH_DONE: begin
					if (rx_byte == CH_R) begin
						push       = 1'b1;
						cmd.status = ST_RESETTING;
						cmd.rreq   = 1'b1;
						phase_d    = PH_WAIT;
						count_d    = 8'd0;
						sum_d      = 8'd0;
						len_d      = 8'd0;
					end else begin
						phase_d = PH_HALT;
					end
				end
				PH_SYNC: begin
					push = 1'b1;
					if (rx_byte == CH_S) begin
						cmd.tx_valid = 1'b1;
						cmd.tx_byte  = CH_S;
						cmd.status   = ST_DOWNLOAD;
						count_d      = 8'd0;
						phase_d      = PH_VERSION;
					end else begin
						cmd.status = ST_SYNC_ERR;
						phase_d    = PH_HALT;
					end
				end
				PH_VERSION: begin
					ver_we  = (count_q < 8'(ID_BYTES));
					count_d = count_inc;
					if (count_inc >= 8'(ID_BYTES)) begin
						phase_d = PH_LENGTH;
					end
				end
				PH_LENGTH: begin
					len_d   = rx_byte;
					sum_d   = rx_byte;
					phase_d = PH_ADDR_HI;
				end
				PH_ADDR_HI: begin
					sum_d   = sum_add;
					phase_d = PH_ADDR_LO;
				end
				PH_ADDR_LO: begin
					sum_d   = sum_add;
					phase_d = PH_TYPE;
				end
				PH_TYPE: begin
					sum_d   = sum_add;
					count_d = 8'd0;
					phase_d = (len_q == 8'd0) ? PH_CHECK : PH_DATA;
				end
				PH_DATA: begin
					sum_d   = sum_add;
					count_d = count_inc;
					if (count_inc >= len_q) begin
						phase_d = PH_CHECK;
					end
				end
				PH_CHECK: begin
					push         = 1'b1;
					cmd.tx_valid = 1'b1;
					if ((8'd0 - sum_q) != rx_byte) begin
						cmd.tx_byte = CH_C;
						cmd.status  = ST_CSUM_FAIL;
						phase_d     = PH_HALT;
					end else if (len_q == 8'd0) begin
						cmd.kind    = CMD_COMMIT;
						cmd.tx_byte = CH_E;
						cmd.status  = ST_SUCCESS;
						phase_d     = PH_DONE;
					end else begin
						cmd.tx_byte = CH_K;
						cmd.status  = ST_DOWNLOAD;
						phase_d     = PH_SYNC;
					end
				end
				default: begin
					phase_d = PH_HALT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			count_q <= 8'd0;
			sum_q   <= 8'd0;
			len_q   <= 8'd0;
		end else begin
			phase_q <= phase_d;
			count_q <= count_d;
			sum_q   <= sum_d;
			len_q   <= len_d;
		end
	end

	// record version bytes, no reset
	always_ff @(posedge clk) begin
		if (ver_we) begin
			ver_q[count_q[IDX_W-1:0]] <= rx_byte;
		end
	end

endmodule

// File: hw/rtl/sbdr_cmd_fifo.sv
`timescale 1ns / 1ps
// sbdr_cmd_fifo: short command queue between the front and back parts.
// Uses sbdr_pkg.
module sbdr_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sbdr_pkg::cmd_t push_cmd,
	input  logic           pop,
	output sbdr_pkg::cmd_t head,
	output logic           empty,
	output logic           full
);
	import sbdr_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push, do_pop;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// File: hw/rtl/sbdr_back.sv
`timescale 1ns / 1ps
// sbdr_back: expands reply commands into reply requests, holds the saved
// version and the output register. Uses sbdr_pkg.
module sbdr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  sbdr_pkg::cmd_t     head,
	input  logic               q_empty,
	output logic               pop,
	input  sbdr_pkg::version_t rec_version,
	input  logic [55:0]        id_high,
	input  logic [63:0]        id_low,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               tx_valid,
	output logic [7:0]         tx_byte,
	output logic               last_of_run,
	output logic [3:0]         link_status,
	output logic               reset_request
);
	import sbdr_pkg::*;

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	version_t         saved_q;
	logic             ov_q, txv_q, last_q, rreq_q;
	logic [7:0]       txb_q;
	logic [3:0]       st_q;
	logic             load_ok;
	logic [7:0]       burst_byte;
	logic [IDX_W-1:0] sv_idx;
	logic             burst_last;

	assign load_ok    = !ov_q || out_ready;
	assign pop        = load_ok && !busy_q && !q_empty;
	assign sv_idx     = IDX_W'(cnt_q - CNT_W'(ID_BYTES + 1));
	assign burst_last = (cnt_q == CNT_W'(2 * ID_BYTES));
	assign burst_byte = (cnt_q <= CNT_W'(ID_BYTES))
		? id_byte(id_high, id_low, CNT_W'(cnt_q - 1'b1)) : saved_q[sv_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			saved_q <= '0;
			ov_q    <= 1'b0;
			txv_q   <= 1'b0;
			txb_q   <= 8'd0;
			last_q  <= 1'b0;
			st_q    <= ST_WAITING;
			rreq_q  <= 1'b0;
		end else if (load_ok) begin
			if (busy_q) begin
				ov_q   <= 1'b1;
				txv_q  <= 1'b1;
				txb_q  <= burst_byte;
				st_q   <= ST_CONNECTED;
				rreq_q <= 1'b0;
				last_q <= burst_last;
				cnt_q  <= cnt_q + 1'b1;
				if (burst_last) begin
					busy_q <= 1'b0;
				end
			end else if (!q_empty) begin
				ov_q <= 1'b1;
				unique case (head.kind)
					CMD_BURST: begin
						txv_q  <= 1'b1;
						txb_q  <= CH_P;
						st_q   <= ST_CONNECTED;
						rreq_q <= 1'b0;
						last_q <= 1'b0;
						busy_q <= 1'b1;
						cnt_q  <= CNT_W'(1);
					end
					CMD_COMMIT: begin
						saved_q <= rec_version;
						txv_q   <= head.tx_valid;
						txb_q   <= head.tx_byte;
						st_q    <= head.status;
						rreq_q  <= head.rreq;
						last_q  <= 1'b1;
					end
					default: begin
						txv_q  <= head.tx_valid;
						txb_q  <= head.tx_byte;
						st_q   <= head.status;
						rreq_q <= head.rreq;
						last_q <= 1'b1;
					end
				endcase
			end else begin
				ov_q <= 1'b0;
			end
		end
	end

	assign out_valid     = ov_q;
	assign tx_valid      = txv_q;
	assign tx_byte       = txb_q;
	assign last_of_run   = last_q;
	assign link_status   = st_q;
	assign reset_request = rreq_q;

endmodule

// File: hw/rtl/serial_hex_download_receiver.sv
`timescale 1ns / 1ps
// serial_hex_download_receiver: top level; device id registers, protocol
// front end, command queue and reply back end. Uses sbdr_pkg and sbdr_* modules.
// path: a reply request passes through the command queue and then the output register
// throughput: one received byte per cycle while the four-entry command queue has room;
// the handshake burst holds the output register for 31 requests, one request a cycle while out_ready is high
// reset: arst_n clears protocol state, id registers and the saved version
module serial_hex_download_receiver (
	input  logic        clk,
	input  logic        arst_n,
	// received bytes
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	// reply requests
	output logic        out_valid,
	input  logic        out_ready,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        last_of_run,
	output logic [3:0]  link_status,
	output logic        reset_request,
	// configuration writes
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import sbdr_pkg::*;

	logic [55:0] id_high_q;
	logic [63:0] id_low_q;
	logic        acc;
	logic        q_push, q_pop, q_empty, q_full;
	cmd_t        q_in, q_head;
	version_t    rec_version;

	// device id registers; the user must write them only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_high_q <= '0;
			id_low_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ID_HIGH: id_high_q <= cfg_data[55:0];
				CFG_ID_LOW:  id_low_q  <= cfg_data;
				default:     id_low_q  <= id_low_q;
			endcase
		end
	end

	// every byte needs a free queue slot, so a commit always leaves the queue
	// before the next record version can be written
	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;

	// front: phase machine, checksum and record version
	sbdr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (acc),
		.rx_byte     (rx_byte),
		.push        (q_push),
		.cmd         (q_in),
		.rec_version (rec_version)
	);

	// queue decouples byte intake from reply output stalls
	sbdr_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_in),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty),
		.full     (q_full)
	);

	// back: expands commands, owns saved version and output register
	sbdr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (q_head),
		.q_empty       (q_empty),
		.pop           (q_pop),
		.rec_version   (rec_version),
		.id_high       (id_high_q),
		.id_low        (id_low_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.tx_valid      (tx_valid),
		.tx_byte       (tx_byte),
		.last_of_run   (last_of_run),
		.link_status   (link_status),
		.reset_request (reset_request)
	);

endmodule
